FILE: hdl/wsb_pkg.sv
// ----------------------------------------------------------------------------
// wsb_pkg
// Shared constants, action codes and the job and result records of the
// wheel speed balancer.
// ----------------------------------------------------------------------------
package wsb_pkg;

    localparam int RATIO_FRAC_BITS_DEF = 12;
    localparam int QUO_W               = 21;
    localparam int DIV_NW              = 38;
    localparam int DEN_W               = 17;
    localparam int JOB_Q_DEPTH         = 4;
    localparam int RES_Q_DEPTH         = 2;

    localparam logic [20:0] RATIO_MAX       = 21'd1048575;
    localparam logic [14:0] DRIVE_LIMIT_RST = 15'd25600;
    localparam logic [15:0] DRIVE_MAX       = 16'h7FFF;
    localparam logic [15:0] DRIVE_MIN       = 16'h8000;
    localparam logic [20:0] DRIVE_MAX_MAG   = 21'd32767;
    localparam logic [20:0] DRIVE_MIN_MAG   = 21'd32768;

    typedef enum logic [2:0] {
        ACT_HELD        = 3'd0,
        ACT_EQUAL       = 3'd1,
        ACT_LEFT_RAISE  = 3'd2,
        ACT_RIGHT_LOWER = 3'd3,
        ACT_RIGHT_RAISE = 3'd4,
        ACT_LEFT_LOWER  = 3'd5
    } t_action;

    typedef struct packed {
        logic [DIV_NW-1:0]  rat_num;
        logic [DEN_W-1:0]   rat_den;
        logic [DIV_NW-1:0]  drv_num;
        logic [DEN_W-1:0]   drv_den;
        logic               rat_use;
        logic               rat_neg;
        logic [20:0]        ratio_fix;
        logic               flag_fix;
        logic               drv_use;
        logic               drv_left;
        logic               drv_neg;
        logic [15:0]        lo;
        logic [15:0]        ro;
        logic [16:0]        err;
        t_action            act;
    } t_job;

    typedef struct packed {
        logic [15:0] left_drive_next;
        logic [15:0] right_drive_next;
        logic [20:0] speed_ratio;
        logic        ratio_overflow;
        logic [16:0] speed_error;
        t_action     action;
    } t_result;

    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

FILE: hdl/wheel_speed_balance.sv
// ----------------------------------------------------------------------------
// wheel_speed_balance
// Differential drive balancer: corrects both wheel drives from their speeds.
//
// Requests enter on push/full with both targets, drives and speeds; results
// leave on empty/pop, oldest first, one result per request. drive_limit is
// set through the APB port at byte address 0 and reads back there.
// From an accepted push to a result showing on the result ports, a request
// passes the first front stage, loaded by the accepting edge, the second
// front stage (classify, multiply), the job queue, the issue stage, 21
// divider stages, and the result queue.
// Throughput is one request per cycle while full stays low; the two pipelined
// dividers (one quotient bit per stage) set the depth, not the rate.
// Reset clears all queues and valid state and loads drive_limit with 100.0.
// When the receiver stops popping, the back end stalls as a unit, the job
// queue fills, and full rises once the front end can no longer advance.
// ----------------------------------------------------------------------------
module wheel_speed_balance
    import wsb_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_left_target,
    input  logic [15:0] i_right_target,
    input  logic [15:0] i_left_drive_now,
    input  logic [15:0] i_right_drive_now,
    input  logic [15:0] i_left_speed,
    input  logic [15:0] i_right_speed,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_left_drive_next,
    output logic [15:0] o_right_drive_next,
    output logic [20:0] o_speed_ratio,
    output logic        o_ratio_overflow,
    output logic [16:0] o_speed_error,
    output logic [2:0]  o_action,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [14:0] r_limit;
    logic        job_valid;
    t_job        job_in;
    logic        job_full;
    logic        job_empty;
    logic        job_pop;
    t_job        job_out;
    logic        res_valid;
    t_result     res_in;
    logic        res_full;
    t_result     res_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= DRIVE_LIMIT_RST;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_limit <= pwdata[14:0];
        end
    end

    wsb_front #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_limit           (r_limit),
        .i_left_target     (i_left_target),
        .i_right_target    (i_right_target),
        .i_left_drive_now  (i_left_drive_now),
        .i_right_drive_now (i_right_drive_now),
        .i_left_speed      (i_left_speed),
        .i_right_speed     (i_right_speed),
        .o_job_valid       (job_valid),
        .o_job             (job_in),
        .i_job_full        (job_full)
    );

    wsb_fifo #(.WIDTH($bits(t_job)), .DEPTH(JOB_Q_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    wsb_back #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_res_valid (res_valid),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    wsb_fifo #(.WIDTH($bits(t_result)), .DEPTH(RES_Q_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_left_drive_next  = res_out.left_drive_next;
    assign o_right_drive_next = res_out.right_drive_next;
    assign o_speed_ratio      = res_out.speed_ratio;
    assign o_ratio_overflow   = res_out.ratio_overflow;
    assign o_speed_error      = res_out.speed_error;
    assign o_action           = res_out.action;

endmodule

FILE: hdl/wsb_fifo.sv
// ----------------------------------------------------------------------------
// wsb_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module wsb_fifo
    import wsb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

FILE: hdl/wsb_front.sv
// ----------------------------------------------------------------------------
// wsb_front
// Front end: registers a request, classifies it, forms the products and the
// limit checks, and builds the divider job for the back end.
// ----------------------------------------------------------------------------
module wsb_front
    import wsb_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [14:0] i_limit,
    input  logic [15:0] i_left_target,
    input  logic [15:0] i_right_target,
    input  logic [15:0] i_left_drive_now,
    input  logic [15:0] i_right_drive_now,
    input  logic [15:0] i_left_speed,
    input  logic [15:0] i_right_speed,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_full
);

    logic               fen;
    logic               r_v1;
    logic [15:0]        r_lt;
    logic [15:0]        r_rt;
    logic signed [15:0] r_la1;
    logic signed [15:0] r_ra1;
    logic signed [15:0] r_ls;
    logic signed [15:0] r_rs;

    logic               r_v2;
    logic               r_held;
    logic               r_lz;
    logic               r_rz;
    logic               r_ls_neg;
    logic               r_rs_neg;
    logic               r_less;
    logic               r_eq;
    logic [15:0]        r_la;
    logic [15:0]        r_ra;
    logic [15:0]        r_mls;
    logic [15:0]        r_mrs;
    logic [16:0]        r_err;
    logic signed [31:0] r_pa;
    logic signed [31:0] r_pb;
    logic [30:0]        r_qa;
    logic [30:0]        r_qb;

    logic [31:0]        mpa;
    logic [31:0]        mpb;
    logic [DIV_NW-1:0]  rat_n;

    assign fen         = !(r_v2 && i_job_full);
    assign o_full      = !fen;
    assign o_job_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (fen) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_lt  <= i_left_target;
            r_rt  <= i_right_target;
            r_la1 <= i_left_drive_now;
            r_ra1 <= i_right_drive_now;
            r_ls  <= i_left_speed;
            r_rs  <= i_right_speed;

            r_held   <= (r_lt == '0) || (r_rt == '0);
            r_lz     <= (r_ls == '0);
            r_rz     <= (r_rs == '0);
            r_ls_neg <= r_ls[15];
            r_rs_neg <= r_rs[15];
            r_less   <= r_rs[15] ? (r_ls > r_rs) : (r_ls < r_rs);
            r_eq     <= (r_ls == r_rs);
            r_la     <= r_la1;
            r_ra     <= r_ra1;
            r_mls    <= mag16(r_ls);
            r_mrs    <= mag16(r_rs);
            r_err    <= 17'({r_rs[15], r_rs} - {r_ls[15], r_ls});
            r_pa     <= r_rs * r_la1;
            r_pb     <= r_ls * r_ra1;
            r_qa     <= i_limit * mag16(r_ls);
            r_qb     <= i_limit * mag16(r_rs);
        end
    end

    assign mpa   = mag32(r_pa);
    assign mpb   = mag32(r_pb);
    assign rat_n = DIV_NW'(r_mls) << RATIO_FRAC_BITS;

    always_comb begin
        o_job           = '0;
        o_job.rat_num   = (rat_n << 1) + DIV_NW'(r_mrs);
        o_job.rat_den   = {1'b0, r_mrs} << 1;
        o_job.rat_neg   = r_ls_neg ^ r_rs_neg;
        o_job.lo        = r_la;
        o_job.ro        = r_ra;
        o_job.err       = r_err;
        o_job.act       = ACT_HELD;
        priority if (r_held) begin
            o_job.err = '0;
        end else if (r_lz && r_rz) begin
            o_job.flag_fix = 1'b1;
            o_job.act      = ACT_EQUAL;
        end else if (r_rz) begin
            o_job.flag_fix  = 1'b1;
            o_job.ratio_fix = r_ls_neg ? (~RATIO_MAX + 21'd1) : RATIO_MAX;
            o_job.lo        = '0;
            o_job.act       = r_ls_neg ? ACT_LEFT_RAISE : ACT_LEFT_LOWER;
        end else if (r_lz) begin
            o_job.flag_fix = 1'b1;
            o_job.ro       = '0;
            o_job.act      = ACT_RIGHT_LOWER;
        end else begin
            o_job.rat_use = 1'b1;
            priority if (r_eq) begin
                o_job.act = ACT_EQUAL;
            end else if (r_less && (mpa <= 32'(r_qa))) begin
                o_job.drv_use  = 1'b1;
                o_job.drv_left = 1'b1;
                o_job.drv_neg  = r_pa[31] ^ r_ls_neg;
                o_job.drv_num  = (DIV_NW'(mpa) << 1) + DIV_NW'(r_mls);
                o_job.drv_den  = {1'b0, r_mls} << 1;
                o_job.act      = ACT_LEFT_RAISE;
            end else if (r_less) begin
                o_job.drv_use  = 1'b1;
                o_job.drv_neg  = r_pb[31] ^ r_rs_neg;
                o_job.drv_num  = (DIV_NW'(mpb) << 1) + DIV_NW'(r_mrs);
                o_job.drv_den  = {1'b0, r_mrs} << 1;
                o_job.act      = ACT_RIGHT_LOWER;
            end else if (mpb <= 32'(r_qb)) begin
                o_job.drv_use  = 1'b1;
                o_job.drv_neg  = r_pb[31] ^ r_rs_neg;
                o_job.drv_num  = (DIV_NW'(mpb) << 1) + DIV_NW'(r_mrs);
                o_job.drv_den  = {1'b0, r_mrs} << 1;
                o_job.act      = ACT_RIGHT_RAISE;
            end else begin
                o_job.drv_use  = 1'b1;
                o_job.drv_left = 1'b1;
                o_job.drv_neg  = r_pa[31] ^ r_ls_neg;
                o_job.drv_num  = (DIV_NW'(mpa) << 1) + DIV_NW'(r_mls);
                o_job.drv_den  = {1'b0, r_mls} << 1;
                o_job.act      = ACT_LEFT_LOWER;
            end
        end
    end

endmodule

FILE: hdl/wsb_div.sv
// ----------------------------------------------------------------------------
// wsb_div
// Pipelined restoring divider, one quotient bit per stage, with a quotient
// overflow flag taken at entry.
// ----------------------------------------------------------------------------
module wsb_div
    import wsb_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DEN_W,
    parameter int QW = QUO_W
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic          r_ovf [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [CW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          ovf_in;
        logic [CW-1:0] trial;
        logic          fits;

        if (k == 0) begin : g_first
            assign rem_in = CW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            assign ovf_in = CW'(i_num) >= (CW'(i_den) << QW);
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign ovf_in = r_ovf[k-1];
        end

        assign trial = CW'(den_in) << (QW - 1 - k);
        assign fits  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? rem_in - trial : rem_in;
                r_den[k] <= den_in;
                r_quo[k] <= quo_in | (fits ? (QW'(1) << (QW - 1 - k)) : '0);
                r_ovf[k] <= ovf_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_ovf = r_ovf[QW-1];

endmodule

FILE: hdl/wsb_back.sv
// ----------------------------------------------------------------------------
// wsb_back
// Back end: takes jobs from the queue, runs the ratio and drive divisions
// in parallel pipelines, then rounds, saturates and assembles the result.
// ----------------------------------------------------------------------------
module wsb_back
    import wsb_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_full
);

    logic             ben;
    logic             r_v0;
    t_job             r_job;
    logic [QUO_W-1:0] r_vs;
    t_job             r_sb [QUO_W];
    t_job             j;

    logic [QUO_W-1:0] rat_quo;
    logic             rat_ovf;
    logic [QUO_W-1:0] drv_quo;
    logic             drv_ovf;

    logic             rbig;
    logic [20:0]      rmag;
    logic [15:0]      dv;

    assign ben       = !(r_vs[QUO_W-1] && i_res_full);
    assign o_job_pop = ben && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vs <= '0;
        end else if (ben) begin
            r_v0 <= i_job_valid;
            r_vs <= {r_vs[QUO_W-2:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_job <= i_job;
            r_sb[0] <= r_job;
            for (int k = 1; k < QUO_W; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    wsb_div #(.NW(DIV_NW), .DW(DEN_W), .QW(QUO_W)) u_rat_div (
        .i_clk (i_clk),
        .i_en  (ben),
        .i_num (r_job.rat_num),
        .i_den (r_job.rat_den),
        .o_quo (rat_quo),
        .o_ovf (rat_ovf)
    );

    wsb_div #(.NW(DIV_NW), .DW(DEN_W), .QW(QUO_W)) u_drv_div (
        .i_clk (i_clk),
        .i_en  (ben),
        .i_num (r_job.drv_num),
        .i_den (r_job.drv_den),
        .o_quo (drv_quo),
        .o_ovf (drv_ovf)
    );

    assign j           = r_sb[QUO_W-1];
    assign o_res_valid = r_vs[QUO_W-1];

    assign rbig = rat_ovf || rat_quo[QUO_W-1];
    assign rmag = rbig ? RATIO_MAX : {1'b0, rat_quo[19:0]};

    always_comb begin
        if (j.drv_neg) begin
            dv = (drv_ovf || (drv_quo > DRIVE_MIN_MAG)) ? DRIVE_MIN
                                                        : 16'(~drv_quo + 1'b1);
        end else begin
            dv = (drv_ovf || (drv_quo > DRIVE_MAX_MAG)) ? DRIVE_MAX : drv_quo[15:0];
        end
    end

    always_comb begin
        o_res.left_drive_next  = (j.drv_use && j.drv_left) ? dv : j.lo;
        o_res.right_drive_next = (j.drv_use && !j.drv_left) ? dv : j.ro;
        o_res.speed_ratio      = j.rat_use ? (j.rat_neg ? (~rmag + 21'd1) : rmag)
                                           : j.ratio_fix;
        o_res.ratio_overflow   = j.flag_fix || (j.rat_use && rbig);
        o_res.speed_error      = j.err;
        o_res.action           = j.act;
    end

    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && j.act == ACT_HELD) |->
            (o_res.speed_ratio == '0 && !o_res.ratio_overflow && o_res.speed_error == '0))
        else $error("held request with nonzero ratio, flag or error");

    a_raise_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && j.drv_use &&
            (j.act == ACT_LEFT_RAISE || j.act == ACT_RIGHT_RAISE)) |->
            (!drv_ovf && drv_quo <= DRIVE_MAX_MAG))
        else $error("raised drive exceeds drive range");

    a_equal_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && j.rat_use && j.act == ACT_EQUAL) |->
            (!rat_ovf && rat_quo == (QUO_W'(1) << RATIO_FRAC_BITS)))
        else $error("equal speeds give a ratio other than one");

endmodule

FILE: verif/wsb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsb_checker
// Watches the request and result queues of the wheel speed balancer, works
// out the corrected drives for each accepted request and compares every
// popped result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module wsb_checker
    import wsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] i_left_target,
    input  logic [15:0] i_right_target,
    input  logic [15:0] i_left_drive_now,
    input  logic [15:0] i_right_drive_now,
    input  logic [15:0] i_left_speed,
    input  logic [15:0] i_right_speed,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] o_left_drive_next,
    input  logic [15:0] o_right_drive_next,
    input  logic [20:0] o_speed_ratio,
    input  logic        o_ratio_overflow,
    input  logic [16:0] o_speed_error,
    input  logic [2:0]  o_action,
    input  logic [14:0] i_drive_limit,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    t_result expected_q[$];

    function automatic longint mag_of(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint div_round(input longint num, input longint den);
        longint q;
        q = (2 * mag_of(num) + mag_of(den)) / (2 * mag_of(den));
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_result balance_drives(
        input logic [15:0] lt_b, rt_b, la_b, ra_b, ls_b, rs_b, input logic [14:0] lim_b
    );
        longint ls, rs, la, ra, lim, lo, ro, ratio, err, r, num;
        logic flag;
        t_action act;
        t_result res;
        ls = longint'($signed(ls_b));
        rs = longint'($signed(rs_b));
        la = longint'($signed(la_b));
        ra = longint'($signed(ra_b));
        lim = longint'(lim_b);
        lo = la;
        ro = ra;
        ratio = 0;
        err = 0;
        flag = 1'b0;
        act = ACT_HELD;
        if (lt_b != 16'd0 && rt_b != 16'd0) begin
            err = rs - ls;
            if (ls == 0 && rs == 0) begin
                flag = 1'b1;
                act = ACT_EQUAL;
            end else if (rs == 0) begin
                flag = 1'b1;
                ratio = ls > 0 ? 1048575 : -1048575;
                lo = 0;
                act = ls > 0 ? ACT_LEFT_LOWER : ACT_LEFT_RAISE;
            end else if (ls == 0) begin
                flag = 1'b1;
                ro = 0;
                act = ACT_RIGHT_LOWER;
            end else begin
                r = div_round(ls * (longint'(1) << RATIO_FRAC_BITS_DEF), rs);
                if (r > 1048575 || r < -1048575) flag = 1'b1;
                ratio = clamp(r, -1048575, 1048575);
                if (ls == rs) begin
                    act = ACT_EQUAL;
                end else if (rs > 0 ? (ls < rs) : (ls > rs)) begin
                    num = rs * la;
                    if (mag_of(num) <= lim * mag_of(ls)) begin
                        lo = div_round(num, ls);
                        act = ACT_LEFT_RAISE;
                    end else begin
                        ro = clamp(div_round(ls * ra, rs), -32768, 32767);
                        act = ACT_RIGHT_LOWER;
                    end
                end else begin
                    num = ls * ra;
                    if (mag_of(num) <= lim * mag_of(rs)) begin
                        ro = div_round(num, rs);
                        act = ACT_RIGHT_RAISE;
                    end else begin
                        lo = clamp(div_round(rs * la, ls), -32768, 32767);
                        act = ACT_LEFT_LOWER;
                    end
                end
            end
        end
        res.left_drive_next  = lo[15:0];
        res.right_drive_next = ro[15:0];
        res.speed_ratio      = ratio[20:0];
        res.ratio_overflow   = flag;
        res.speed_error      = err[16:0];
        res.action           = act;
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (!i_rst_n) begin
            expected_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (pop && !empty) begin
                got.left_drive_next  = o_left_drive_next;
                got.right_drive_next = o_right_drive_next;
                got.speed_ratio      = o_speed_ratio;
                got.ratio_overflow   = o_ratio_overflow;
                got.speed_error      = o_speed_error;
                got.action           = t_action'(o_action);
                o_result_count <= o_result_count + 1;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch expected %p got %p",
                                     $realtime, exp_r, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (push && !full)
                expected_q.push_back(balance_drives(i_left_target, i_right_target,
                    i_left_drive_now, i_right_drive_now, i_left_speed, i_right_speed,
                    i_drive_limit));
        end
    end

endmodule

FILE: verif/wheel_speed_balance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_speed_balance_tb
// Drives directed and random requests into the wheel speed balancer under
// bursty pushes and stalled pops, across several drive limits set over APB,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module wheel_speed_balance_tb;
    import wsb_pkg::*;

    localparam int LATENCY = 26;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] lt = '0, rt = '0, la = '0, ra = '0, ls = '0, rs = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_ldn, o_rdn;
    logic [20:0] o_ratio;
    logic        o_ovf;
    logic [16:0] o_err;
    logic [2:0]  o_act;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [14:0] drive_limit = DRIVE_LIMIT_RST;
    int          fail_count, pending, result_count;
    int          request_count = 0;
    bit          pop_pattern_on = 1'b0;

    always #5 i_clk = ~i_clk;

    wheel_speed_balance uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_left_target(lt), .i_right_target(rt),
        .i_left_drive_now(la), .i_right_drive_now(ra),
        .i_left_speed(ls), .i_right_speed(rs),
        .empty(empty), .pop(pop),
        .o_left_drive_next(o_ldn), .o_right_drive_next(o_rdn),
        .o_speed_ratio(o_ratio), .o_ratio_overflow(o_ovf),
        .o_speed_error(o_err), .o_action(o_act),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wsb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_left_target(lt), .i_right_target(rt),
        .i_left_drive_now(la), .i_right_drive_now(ra),
        .i_left_speed(ls), .i_right_speed(rs),
        .empty(empty), .pop(pop),
        .o_left_drive_next(o_ldn), .o_right_drive_next(o_rdn),
        .o_speed_ratio(o_ratio), .o_ratio_overflow(o_ovf),
        .o_speed_error(o_err), .o_action(o_act),
        .i_drive_limit(drive_limit),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    // receiver: stall on a pattern of its own, with free-running stretches
    always @(posedge i_clk) begin
        int phase;
        if (!i_rst_n) begin
            pop <= 1'b0;
            phase = 0;
        end else begin
            phase = phase + 1;
            if (phase[8:7] == 2'b00)
                pop <= 1'b1;
            else if (phase[8:7] == 2'b01)
                pop <= (phase % 5) != 0;
            else
                pop <= ($urandom_range(0, 99) < 45);
        end
    end

    task automatic write_limit(input logic [14:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {17'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        drive_limit <= value;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // hold one request until the block accepts it
    task automatic send_request(input logic [15:0] a, b, c, d, e, f);
        push <= 1'b1;
        lt <= a; rt <= b; la <= c; ra <= d; ls <= e; rs <= f;
        do @(posedge i_clk); while (full);
        request_count++;
    endtask

    function automatic logic [15:0] rand_drive();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 51200) - 25600;
            1: v = $urandom_range(0, 1) ? 25600 : -25600;
            2: v = $urandom_range(0, 512) - 256;
            default: v = $urandom_range(0, 65535);
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] rand_speed();
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = $urandom_range(0, 800) - 400;
            2: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: v = $urandom_range(0, 65535);
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] rand_target();
        return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    endfunction

    task automatic random_phase(input int n);
        logic [15:0] s;
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0) begin
                s = rand_speed();
                if ($urandom_range(0, 3) == 0)
                    send_request(rand_target(), rand_target(), rand_drive(), rand_drive(),
                                 s, s + 16'($urandom_range(0, 6)) - 16'd3);
                else
                    send_request(rand_target(), rand_target(), rand_drive(), rand_drive(),
                                 s, rand_speed());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        push <= 1'b0;
    endtask

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: held, equal, zero speeds, extremes, raise and lower
        send_request(16'd0, 16'd5, 16'd1000, 16'hF000, 16'd100, 16'd200);
        send_request(16'd5, 16'd0, 16'd1000, 16'd2000, 16'd100, 16'd200);
        send_request(16'd1, 16'd1, 16'd1000, 16'd2000, 16'd0, 16'd0);
        send_request(16'd1, 16'd1, 16'd1000, 16'd2000, 16'd50, 16'd0);
        send_request(16'd1, 16'd1, 16'd1000, 16'd2000, 16'hFFCE, 16'd0);
        send_request(16'd1, 16'd1, 16'd1000, 16'd2000, 16'd0, 16'hFFCE);
        send_request(16'h7FFF, 16'h8001, 16'd1000, 16'd2000, 16'd300, 16'd300);
        send_request(16'd1, 16'd1, 16'd10000, 16'd10000, 16'd100, 16'd200);
        send_request(16'd1, 16'd1, 16'd20000, 16'd20000, 16'd100, 16'd200);
        send_request(16'd1, 16'd1, 16'd10000, 16'd10000, 16'd200, 16'd100);
        send_request(16'd1, 16'd1, 16'd20000, 16'd20000, 16'd200, 16'd100);
        send_request(16'd1, 16'd1, 16'd25600, 16'h9C00, 16'h8000, 16'd1);
        send_request(16'd1, 16'd1, 16'h9C00, 16'd25600, 16'd1, 16'h8000);
        send_request(16'd1, 16'd1, 16'd25600, 16'd25600, 16'h7FFF, 16'd1);
        send_request(16'd1, 16'd1, 16'h9C00, 16'h9C00, 16'hFF00, 16'hFE00);
        send_request(16'd1, 16'd1, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_request(16'd1, 16'd1, 16'd3, 16'd3, 16'd3, 16'd2);
        push <= 1'b0;
        drain_results();

        write_limit(15'd0);
        random_phase(200);
        drain_results();
        write_limit(15'h7FFF);
        random_phase(250);
        drain_results();
        write_limit(15'd12800);
        random_phase(250);
        drain_results();
        write_limit(DRIVE_LIMIT_RST);
        random_phase(330);
        drain_results();

        $display("Covered %0d requests and %0d results over drive limits 0, 12800, 25600, 32767.",
                 request_count, result_count);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
